// ----- rtl/core/mck_pkg.sv -----
// ----------------------------------------------------------------------------
// mck_pkg: shared types and tables for the Morse character keyer
// Holds the segment descriptors and the Morse element tables for letters and
// digits. Patterns are stored first element in bit 0, a 1 bit is a dash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

    localparam int UNIT_W = 10;
    localparam int DUR_W  = 13;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 3;
    localparam int PAT_W  = 5;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 10'd200;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;

    // Segment length in Morse units
    typedef enum logic [1:0] {
        UNITS_1 = 2'd0,
        UNITS_3 = 2'd1,
        UNITS_7 = 2'd2
    } units_t;

    // Decoded character
    typedef struct packed {
        logic             is_code;
        logic             is_space;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] dash;
    } code_t;

    // One segment handed from the sequencer to the output stage
    typedef struct packed {
        logic   led_on;
        units_t units;
        logic   last;
    } seg_t;

    // {length, dash pattern}, first element in bit 0
    localparam logic [LEN_W+PAT_W-1:0] LETTER_CODE [26] = '{
        {3'd2, 5'b00010},  // A .-
        {3'd4, 5'b00001},  // B -...
        {3'd4, 5'b00101},  // C -.-.
        {3'd3, 5'b00001},  // D -..
        {3'd1, 5'b00000},  // E .
        {3'd4, 5'b00100},  // F ..-.
        {3'd3, 5'b00011},  // G --.
        {3'd4, 5'b00000},  // H ....
        {3'd2, 5'b00000},  // I ..
        {3'd4, 5'b01110},  // J .---
        {3'd3, 5'b00101},  // K -.-
        {3'd4, 5'b00010},  // L .-..
        {3'd2, 5'b00011},  // M --
        {3'd2, 5'b00001},  // N -.
        {3'd3, 5'b00111},  // O ---
        {3'd4, 5'b00110},  // P .--.
        {3'd4, 5'b01011},  // Q --.-
        {3'd3, 5'b00010},  // R .-.
        {3'd3, 5'b00000},  // S ...
        {3'd1, 5'b00001},  // T -
        {3'd3, 5'b00100},  // U ..-
        {3'd4, 5'b01000},  // V ...-
        {3'd3, 5'b00110},  // W .--
        {3'd4, 5'b01001},  // X -..-
        {3'd4, 5'b01101},  // Y -.--
        {3'd4, 5'b00011}   // Z --..
    };

    // Digits are all five elements long
    localparam logic [PAT_W-1:0] DIGIT_DASH [10] = '{
        5'b11111,  // 0 -----
        5'b11110,  // 1 .----
        5'b11100,  // 2 ..---
        5'b11000,  // 3 ...--
        5'b10000,  // 4 ....-
        5'b00000,  // 5 .....
        5'b00001,  // 6 -....
        5'b00011,  // 7 --...
        5'b00111,  // 8 ---..
        5'b01111   // 9 ----.
    };

    localparam logic [LEN_W-1:0] DIGIT_LEN = 3'd5;

endpackage : mck_pkg

`default_nettype wire

// ----- rtl/core/mck_decode.sv -----
// ----------------------------------------------------------------------------
// mck_decode: character decoder
// Maps an ASCII byte to its Morse element count and dash pattern, flags the
// space character, and marks everything else as producing no output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mck_decode (
    input  wire logic [mck_pkg::CHAR_W-1:0] character,
    output mck_pkg::code_t                  code
);
    import mck_pkg::*;

    logic [CHAR_W-1:0]       lo_off;
    logic [CHAR_W-1:0]       up_off;
    logic [CHAR_W-1:0]       dg_off;
    logic [LEN_W+PAT_W-1:0]  lo_entry;
    logic [LEN_W+PAT_W-1:0]  up_entry;

    assign lo_off   = character - CHAR_LO_A;
    assign up_off   = character - CHAR_UP_A;
    assign dg_off   = character - CHAR_ZERO;
    assign lo_entry = LETTER_CODE[lo_off[4:0]];
    assign up_entry = LETTER_CODE[up_off[4:0]];

    // Classify the byte and look up its pattern
    always_comb begin
        code = '0;
        if (character >= CHAR_LO_A && character <= CHAR_LO_Z) begin
            code.is_code = 1'b1;
            code.len     = lo_entry[LEN_W+PAT_W-1:PAT_W];
            code.dash    = lo_entry[PAT_W-1:0];
        end else if (character >= CHAR_UP_A && character <= CHAR_UP_Z) begin
            code.is_code = 1'b1;
            code.len     = up_entry[LEN_W+PAT_W-1:PAT_W];
            code.dash    = up_entry[PAT_W-1:0];
        end else if (character >= CHAR_ZERO && character <= CHAR_NINE) begin
            code.is_code = 1'b1;
            code.len     = DIGIT_LEN;
            code.dash    = DIGIT_DASH[dg_off[3:0]];
        end else if (character == CHAR_SPACE) begin
            code.is_space = 1'b1;
        end
    end

endmodule : mck_decode

`default_nettype wire

// ----- rtl/core/mck_sequencer.sv -----
// ----------------------------------------------------------------------------
// mck_sequencer: element sequencer
// Shifts the dash pattern out one element at a time and walks each element
// through its lit part and its dark gap, then closes the run with the letter
// gap. A space yields one long dark segment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mck_sequencer (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  mck_pkg::code_t      in_code,
    output logic                seg_valid,
    input  wire logic           seg_ready,
    output mck_pkg::seg_t       seg
);
    import mck_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_GAP,
        ST_TAIL,
        ST_SPACE
    } state_t;

    state_t           state_reg;
    logic [PAT_W-1:0] dash_reg;
    logic [LEN_W-1:0] cnt_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign seg_valid = (state_reg != ST_IDLE);

    // Describe the segment for the current step
    always_comb begin
        seg = '{led_on: 1'b0, units: UNITS_1, last: 1'b0};
        unique case (state_reg)
            ST_MARK: begin
                seg.led_on = 1'b1;
                seg.units  = dash_reg[0] ? UNITS_3 : UNITS_1;
            end
            ST_GAP: begin
                seg.units = UNITS_1;
            end
            ST_TAIL: begin
                seg.units = UNITS_3;
                seg.last  = 1'b1;
            end
            ST_SPACE: begin
                seg.units = UNITS_7;
                seg.last  = 1'b1;
            end
            default: begin
                seg.units = UNITS_1;
            end
        endcase
    end

    // Load a character, then advance one segment per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dash_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        dash_reg <= in_code.dash;
                        cnt_reg  <= in_code.len;
                        if (in_code.is_code) begin
                            state_reg <= ST_MARK;
                        end else if (in_code.is_space) begin
                            state_reg <= ST_SPACE;
                        end
                    end
                end
                ST_MARK: begin
                    if (seg_ready) begin
                        state_reg <= ST_GAP;
                    end
                end
                ST_GAP: begin
                    if (seg_ready) begin
                        dash_reg  <= dash_reg >> 1;
                        cnt_reg   <= cnt_reg - 3'd1;
                        state_reg <= (cnt_reg == 3'd1) ? ST_TAIL : ST_MARK;
                    end
                end
                ST_TAIL, ST_SPACE: begin
                    if (seg_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule : mck_sequencer

`default_nettype wire

// ----- rtl/core/mck_out.sv -----
// ----------------------------------------------------------------------------
// mck_out: output register
// Scales the segment length by the unit register and holds the result until
// the downstream side takes it. Refills in the cycle the held result leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mck_out (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [mck_pkg::UNIT_W-1:0]  unit_ms,
    input  wire logic                        seg_valid,
    output logic                             seg_ready,
    input  mck_pkg::seg_t                    seg,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_led_on,
    output logic [mck_pkg::DUR_W-1:0]        m_duration_ms,
    output logic                             m_last
);
    import mck_pkg::*;

    logic             valid_reg;
    logic             led_on_reg;
    logic             last_reg;
    logic [DUR_W-1:0] dur_reg;
    logic [DUR_W-1:0] dur_next;
    logic [DUR_W-1:0] unit_x1;
    logic [DUR_W-1:0] unit_x2;
    logic [DUR_W-1:0] unit_x8;

    assign unit_x1 = {3'b000, unit_ms};
    assign unit_x2 = {2'b00, unit_ms, 1'b0};
    assign unit_x8 = {unit_ms, 3'b000};

    // Scale by 1, 3 or 7 with shifts and one add or subtract
    always_comb begin
        case (seg.units)
            UNITS_3: dur_next = unit_x2 + unit_x1;
            UNITS_7: dur_next = unit_x8 - unit_x1;
            default: dur_next = unit_x1;
        endcase
    end

    assign seg_ready = !valid_reg || m_ready;

    // Hold the result until transfer, reload when free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (seg_ready) begin
            valid_reg <= seg_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (seg_ready && seg_valid) begin
            led_on_reg <= seg.led_on;
            last_reg   <= seg.last;
            dur_reg    <= dur_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_led_on      = led_on_reg;
    assign m_duration_ms = dur_reg;
    assign m_last        = last_reg;

endmodule : mck_out

`default_nettype wire

// ----- rtl/core/morse_character_keyer_unit.sv -----
// ----------------------------------------------------------------------------
// morse_character_keyer_unit: Morse character keyer
// Keys one ASCII character out as a run of LED segments, each a level and a
// duration in milliseconds scaled by a programmable unit length.
//
//   Channel   Ports                                   Moves
//   s_        s_valid s_ready s_character             one character
//   m_        m_valid m_ready m_led_on m_duration_ms  one segment
//             m_last
//   cfg_      cfg_valid cfg_ready cfg_data            unit length in ms
//
// A character with n elements yields 2n+1 segments, one per cycle after its
// accept cycle while the output is not stalled, and a space yields one;
// an unsupported byte is dropped in its accept cycle.
// Each segment shows on m_ in the cycle after the output register takes it.
// Output stalls hold the sequencer. Reset is synchronous, active low, and
// sets the unit length to 200 ms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module morse_character_keyer_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mck_pkg::UNIT_W-1:0]  cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [mck_pkg::CHAR_W-1:0]  s_character,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_led_on,
    output logic [mck_pkg::DUR_W-1:0]        m_duration_ms,
    output logic                             m_last
);
    import mck_pkg::*;

    logic [UNIT_W-1:0] unit_reg;
    code_t             code;
    seg_t              seg;
    logic              seg_valid;
    logic              seg_ready;

    // Unit length register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= UNIT_RESET;
        end else if (cfg_valid) begin
            unit_reg <= cfg_data;
        end
    end

    mck_decode u_decode (
        .character (s_character),
        .code      (code)
    );

    mck_sequencer u_sequencer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_code   (code),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    mck_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .unit_ms       (unit_reg),
        .seg_valid     (seg_valid),
        .seg_ready     (seg_ready),
        .seg           (seg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_led_on      (m_led_on),
        .m_duration_ms (m_duration_ms),
        .m_last        (m_last)
    );

endmodule : morse_character_keyer_unit

`default_nettype wire

// ----- rtl/core/mck_checker.sv -----
// ----------------------------------------------------------------------------
// mck_checker: port-level checks for the Morse character keyer
// Watches the top level's ports for result ordering and handshake behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mck_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic [mck_pkg::CHAR_W-1:0]  s_character,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic                        m_led_on,
    input  wire logic [mck_pkg::DUR_W-1:0]   m_duration_ms,
    input  wire logic                        m_last
);
    import mck_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_on)
            && $stable(m_duration_ms) && $stable(m_last))
        else $error("stalled result changed");

    // The final segment of a run is always dark
    a_last_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !m_led_on)
        else $error("final segment is lit");

    // A lit segment is followed at once by its dark gap
    a_gap_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_led_on |=> m_valid && !m_led_on && !m_last)
        else $error("lit segment not followed by its gap");

    // A space keeps the input closed for its segment
    a_space_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_character == CHAR_SPACE |=> !s_ready)
        else $error("input open while a space is keyed");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown after reset");

endmodule : mck_checker

bind morse_character_keyer_unit mck_checker u_mck_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_character   (s_character),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_led_on      (m_led_on),
    .m_duration_ms (m_duration_ms),
    .m_last        (m_last)
);

`default_nettype wire

// ----- tb/sv/mck_segment_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mck_segment_checker: segment scoreboard for the Morse character keyer
// Watches the unit-length, character and segment channels. Each accepted
// character is keyed out into the LED segments it must produce, and every
// segment transfer is compared field by field against the oldest one pending.
// ----------------------------------------------------------------------------

module mck_segment_checker
    import mck_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [UNIT_W-1:0] cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [CHAR_W-1:0] s_character,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_led_on,
    input  logic [DUR_W-1:0]  m_duration_ms,
    input  logic              m_last,
    output int                segs_pending,
    output int                fail_total
);

    typedef struct {
        logic             led_on;
        logic [DUR_W-1:0] duration_ms;
        logic             last;
    } keyed_seg_t;

    // Morse elements, first element leftmost
    string letter_pat [26] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
    };
    string digit_pat [10] = '{
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    keyed_seg_t        keyed_segs [$];
    keyed_seg_t        seg_head;
    logic [UNIT_W-1:0] unit_len;
    int                mismatch_cnt;

    initial begin
        segs_pending = 0;
        fail_total   = 0;
        mismatch_cnt = 0;
        unit_len     = UNIT_RESET;
    end

    // Queue one segment scaled by the current unit length
    task automatic add_seg(input logic led, input int mult, input logic fin);
        keyed_seg_t seg;
        seg.led_on      = led;
        seg.duration_ms = DUR_W'(unit_len * mult);
        seg.last        = fin;
        keyed_segs.push_back(seg);
    endtask

    // Expand one character into its run of LED segments
    task automatic key_character(input logic [CHAR_W-1:0] ch);
        string pat;
        int    idx;
        pat = "";
        if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
            pat = letter_pat[ch - CHAR_LO_A];
        end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
            pat = letter_pat[ch - CHAR_UP_A];
        end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            pat = digit_pat[ch - CHAR_ZERO];
        end else if (ch == CHAR_SPACE) begin
            add_seg(1'b0, 7, 1'b1);
            return;
        end else begin
            // drop anything that is not a letter, digit or space
            return;
        end
        for (idx = 0; idx < pat.len(); idx++) begin
            add_seg(1'b1, (pat.getc(idx) == "-") ? 3 : 1, 1'b0);
            add_seg(1'b0, 1, 1'b0);
        end
        // close the character with the inter-letter gap
        add_seg(1'b0, 3, 1'b1);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            keyed_segs.delete();
            unit_len = UNIT_RESET;
        end else begin
            // track the unit length
            if (cfg_valid && cfg_ready) begin
                unit_len = cfg_data;
            end

            // check the segment transfer against the oldest pending one
            if (m_valid && m_ready) begin
                if (keyed_segs.size() == 0) begin
                    $error("unexpected segment: led_on %0d duration_ms %0d last %0d",
                           m_led_on, m_duration_ms, m_last);
                    mismatch_cnt++;
                end else begin
                    seg_head = keyed_segs.pop_front();
                    if (m_led_on !== seg_head.led_on) begin
                        $error("led_on: expected %0d, actual %0d",
                               seg_head.led_on, m_led_on);
                        mismatch_cnt++;
                    end
                    if (m_duration_ms !== seg_head.duration_ms) begin
                        $error("duration_ms: expected %0d, actual %0d",
                               seg_head.duration_ms, m_duration_ms);
                        mismatch_cnt++;
                    end
                    if (m_last !== seg_head.last) begin
                        $error("last: expected %0d, actual %0d",
                               seg_head.last, m_last);
                        mismatch_cnt++;
                    end
                end
            end

            // predict the run of the accepted character
            if (s_valid && s_ready) begin
                key_character(s_character);
            end
        end
        segs_pending <= keyed_segs.size();
        fail_total   <= mismatch_cnt;
    end

endmodule : mck_segment_checker

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Morse character keyer
// Drives directed and random characters and unit lengths with random input
// gaps and random output backpressure; the segment checker predicts and compares
// every keyed segment, and this module reports the verdict.
// ----------------------------------------------------------------------------

module tb_top;
    import mck_pkg::*;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [UNIT_W-1:0] cfg_data    = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [CHAR_W-1:0] s_character = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic              m_led_on;
    logic [DUR_W-1:0]  m_duration_ms;
    logic              m_last;

    int segs_pending;
    int fail_total;
    int send_gap_pct   = 7;
    int recv_stall_pct = 57;

    morse_character_keyer_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_character   (s_character),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_led_on      (m_led_on),
        .m_duration_ms (m_duration_ms),
        .m_last        (m_last)
    );

    mck_segment_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_character   (s_character),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_led_on      (m_led_on),
        .m_duration_ms (m_duration_ms),
        .m_last        (m_last),
        .segs_pending  (segs_pending),
        .fail_total    (fail_total)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stall the segment channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Present one character, with random gaps ahead of it
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= ch;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text(input string txt);
        int idx;
        for (idx = 0; idx < txt.len(); idx++) begin
            send_char(txt.getc(idx));
        end
    endtask

    // Wait for the keyer to drain, then load a new unit length
    task automatic write_unit(input logic [UNIT_W-1:0] val);
        s_valid <= 1'b0;
        do @(posedge aclk); while (segs_pending != 0);
        repeat (16) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly letters, digits and spaces, with some arbitrary bytes
    function automatic logic [CHAR_W-1:0] pick_char();
        int                sel;
        logic [CHAR_W-1:0] ofs;
        sel = $urandom_range(99);
        if (sel < 40) begin
            ofs = CHAR_W'($urandom_range(25));
            return CHAR_UP_A + ofs;
        end else if (sel < 65) begin
            ofs = CHAR_W'($urandom_range(25));
            return CHAR_LO_A + ofs;
        end else if (sel < 80) begin
            ofs = CHAR_W'($urandom_range(9));
            return CHAR_ZERO + ofs;
        end else if (sel < 88) begin
            return CHAR_SPACE;
        end
        return CHAR_W'($urandom_range(255));
    endfunction

    initial begin
        int phase;
        int cnt;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: case, range edges, neighbors of each range, space
        send_text("Az095 EQTm");
        send_char(8'h00);
        send_char(8'hFF);
        send_text("@[`{/:");

        // zero unit, largest unit, smallest and top of the nominal range
        write_unit(10'd0);
        send_text("0 ");
        write_unit(10'd1023);
        send_text("0 ");
        write_unit(10'd1);
        send_text("Y");
        write_unit(10'd1000);
        send_text("7 ");

        // random characters over three backpressure mixes
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct   = 7;
                    recv_stall_pct = 57;
                end
                1: begin
                    send_gap_pct   = 57;
                    recv_stall_pct = 7;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            write_unit(UNIT_W'($urandom_range(1023)));
            for (cnt = 0; cnt < 50; cnt++) begin
                send_char(pick_char());
            end
        end
        s_valid <= 1'b0;

        // drain and give the keyer time to show any stray segment
        do @(posedge aclk); while (segs_pending != 0);
        repeat (24) @(posedge aclk);
        if (fail_total == 0 && segs_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop for a hung handshake
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule : tb_top
